[rtl/core/srl_pkg.sv]
// Shared types, constants and address helper for the sorted reorder list.
`timescale 1ns / 1ps
`default_nettype none
package srl_pkg;

	localparam int CAPACITY = 32;
	localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int SUM_W    = CNT_W + 1;
	localparam int NUM_W    = 32;
	localparam int HND_W    = 16;
	localparam int ENTRY_W  = NUM_W + HND_W;

	localparam logic OP_ADD = 1'b0;
	localparam logic OP_GET = 1'b1;

	localparam logic [2:0] ST_ADDED   = 3'd0;
	localparam logic [2:0] ST_DUP     = 3'd1;
	localparam logic [2:0] ST_FULL    = 3'd2;
	localparam logic [2:0] ST_FOUND   = 3'd3;
	localparam logic [2:0] ST_MISSING = 3'd4;

	typedef struct packed {
		logic             operation;
		logic [NUM_W-1:0] sequence_number;
		logic [HND_W-1:0] fragment_handle;
	} srl_req_t;

	typedef struct packed {
		logic [2:0]       status;
		logic [HND_W-1:0] found_handle;
		logic [5:0]       pending_count;
		logic [5:0]       dropped_count;
	} srl_rsp_t;

	typedef struct packed {
		logic [NUM_W-1:0] number;
		logic [HND_W-1:0] handle;
	} srl_entry_t;

	typedef struct packed {
		logic start;
		logic rsp_free;
	} srl_ctl_t;

	typedef struct packed {
		logic idle;
		logic done;
	} srl_stat_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] addr;
		srl_entry_t        data;
	} srl_wr_t;

	// Map a logical position (offset from head) to a ring slot.
	function automatic logic [ADDR_W-1:0] srl_phys(input logic [ADDR_W-1:0] base,
			input logic [CNT_W-1:0] ofs);
		logic [SUM_W-1:0] sum;
		sum = SUM_W'(base) + SUM_W'(ofs);
		if (sum >= SUM_W'(CAPACITY)) begin
			sum = sum - SUM_W'(CAPACITY);
		end
		return sum[ADDR_W-1:0];
	endfunction

endpackage
`default_nettype wire

[rtl/core/srl_ram.sv]
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module srl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

[rtl/core/srl_seq.sv]
// Sequencer: ring-buffer scan, insert shift and head drain over one compare unit.
`timescale 1ns / 1ps
`default_nettype none
module srl_seq import srl_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire srl_ctl_t          ctl,
	input  wire srl_req_t          req,
	output srl_stat_t              stat,
	output srl_rsp_t               res,
	output srl_wr_t                wr,
	output logic      [ADDR_W-1:0] raddr,
	input  wire srl_entry_t        rdata
);

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_TAIL  = 7'b0000010,
		S_SCAN  = 7'b0000100,
		S_PLACE = 7'b0001000,
		S_SHIFT = 7'b0010000,
		S_PUT   = 7'b0100000,
		S_FIN   = 7'b1000000
	} srl_state_t;

	srl_state_t        state_q, state_d;
	logic              op_q;
	logic [NUM_W-1:0]  key_q;
	logic [HND_W-1:0]  hnd_q;
	logic [ADDR_W-1:0] head_q, head_d;
	logic [CNT_W-1:0]  count_q, count_d;
	logic [CNT_W-1:0]  idx_q, idx_d;
	logic [CNT_W-1:0]  pos_q, pos_d;
	srl_rsp_t          res_q, res_d;
	logic [CNT_W-1:0]  rd_idx;
	logic [CNT_W-1:0]  wr_idx;
	logic [CNT_W-1:0]  drop;
	logic              num_lt;
	logic              num_eq;
	logic              at_end;
	logic              hit;

	// Shared compare unit.
	assign num_lt = rdata.number < key_q;
	assign num_eq = rdata.number == key_q;
	assign at_end = idx_q == count_q;
	assign hit    = !at_end && num_eq;
	assign drop   = hit ? idx_q + CNT_W'(1) : idx_q;

	always_comb begin
		state_d    = state_q;
		idx_d      = idx_q;
		pos_d      = pos_q;
		head_d     = head_q;
		count_d    = count_q;
		res_d      = res_q;
		rd_idx     = idx_q;
		wr_idx     = idx_q;
		wr.we      = 1'b0;
		wr.data    = rdata;
		stat.done  = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (ctl.start) begin
					if (req.operation == OP_ADD && count_q != '0) begin
						rd_idx  = count_q - CNT_W'(1);
						state_d = S_TAIL;
					end else begin
						rd_idx  = '0;
						idx_d   = '0;
						state_d = S_SCAN;
					end
				end
			end
			S_TAIL: begin
				if (num_lt) begin
					pos_d   = count_q;
					state_d = S_PLACE;
				end else begin
					rd_idx  = '0;
					idx_d   = '0;
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				if (at_end || !num_lt) begin
					res_d.found_handle  = '0;
					res_d.dropped_count = '0;
					res_d.pending_count = 6'(count_q);
					if (op_q == OP_ADD) begin
						if (hit) begin
							res_d.status = ST_DUP;
							state_d      = S_FIN;
						end else begin
							pos_d   = idx_q;
							state_d = S_PLACE;
						end
					end else begin
						head_d              = srl_phys(head_q, drop);
						count_d             = count_q - drop;
						res_d.status        = hit ? ST_FOUND : ST_MISSING;
						res_d.found_handle  = hit ? rdata.handle : '0;
						res_d.pending_count = 6'(count_q - drop);
						res_d.dropped_count = 6'(idx_q);
						state_d             = S_FIN;
					end
				end else begin
					idx_d  = idx_q + CNT_W'(1);
					rd_idx = idx_q + CNT_W'(1);
				end
			end
			S_PLACE: begin
				if (count_q == CNT_W'(CAPACITY)) begin
					res_d.status        = ST_FULL;
					res_d.found_handle  = '0;
					res_d.dropped_count = '0;
					res_d.pending_count = 6'(count_q);
					state_d             = S_FIN;
				end else if (pos_q == count_q) begin
					state_d = S_PUT;
				end else begin
					idx_d   = count_q;
					rd_idx  = count_q - CNT_W'(1);
					state_d = S_SHIFT;
				end
			end
			S_SHIFT: begin
				wr.we  = 1'b1;
				wr_idx = idx_q;
				idx_d  = idx_q - CNT_W'(1);
				if (idx_q - CNT_W'(1) == pos_q) begin
					state_d = S_PUT;
				end else begin
					rd_idx = idx_q - CNT_W'(2);
				end
			end
			S_PUT: begin
				wr.we               = 1'b1;
				wr_idx              = pos_q;
				wr.data.number      = key_q;
				wr.data.handle      = hnd_q;
				count_d             = count_q + CNT_W'(1);
				res_d.status        = ST_ADDED;
				res_d.found_handle  = '0;
				res_d.dropped_count = '0;
				res_d.pending_count = 6'(count_q + CNT_W'(1));
				state_d             = S_FIN;
			end
			S_FIN: begin
				if (ctl.rsp_free) begin
					stat.done = 1'b1;
					state_d   = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		wr.addr   = srl_phys(head_q, wr_idx);
		stat.idle = state_q == S_IDLE;
	end

	assign raddr     = srl_phys(head_q, rd_idx);
	assign res       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q  <= '0;
			count_q <= '0;
			idx_q   <= '0;
			pos_q   <= '0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			count_q <= count_d;
			idx_q   <= idx_d;
			pos_q   <= pos_d;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start && stat.idle) begin
			op_q  <= req.operation;
			key_q <= req.sequence_number;
			hnd_q <= req.fragment_handle;
		end
		res_q <= res_d;
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	assert property (@(posedge clk) disable iff (!arst_n)
		wr.we |-> (state_q == S_SHIFT || state_q == S_PUT))
		else $error("store written outside insert");

	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SHIFT |-> pos_q < idx_q)
		else $error("shift passed insert position");

	assert property (@(posedge clk) disable iff (!arst_n)
		count_q != $past(count_q) |->
			($past(state_q) == S_SCAN || $past(state_q) == S_PUT))
		else $error("entry count changed outside get or insert");

	assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.start && stat.idle) |=> !stat.idle)
		else $error("transfer accepted but sequencer stayed idle");

endmodule
`default_nettype wire

[rtl/core/sequence_reorder_list.sv]
// Top level of the sorted reorder list: handshakes, result register, store.
// Sorted reorder list of CAPACITY entries, each a 32-bit sequence number and a
// 16-bit fragment handle, held in ascending order in a ring over one RAM.
// Request channel req_valid/req_ready/req: operation 0 adds an entry, 1 gets
// an entry and drains every older entry from the head.
// Response channel rsp_valid/rsp_ready/rsp: exactly one response per request.
// One request is worked at a time; req_ready is high only while the sequencer
// is idle, and a response may still wait in the output register meanwhile.
// Steps from request transfer to response on rsp, one RAM read per step and
// one shared comparator:
//   add above the largest entry: tail check, full check, then the write
//   add elsewhere: ordered scan, full check, then one slot moved per cycle to
//   open the gap, then the write
//   get: ordered scan; the drop is a head pointer move
// A finished result is registered in the sequencer and passes to the output
// register once that is free; the sequencer then returns to idle.
// Reset empties the list at once; no clearing pass is needed.
// When the receiver stalls, the response is held in the output register and a
// finished result waits in the sequencer until that register frees.
`timescale 1ns / 1ps
`default_nettype none
module sequence_reorder_list import srl_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     req_valid,
	output logic          req_ready,
	input  wire srl_req_t req,
	output logic          rsp_valid,
	input  wire logic     rsp_ready,
	output srl_rsp_t      rsp
);

	srl_ctl_t          ctl;
	srl_stat_t         stat;
	srl_rsp_t          res;
	srl_wr_t           wr;
	logic [ADDR_W-1:0] raddr;
	srl_entry_t        rdata;
	logic              rsp_valid_q;
	srl_rsp_t          rsp_q;

	assign req_ready    = stat.idle;
	assign ctl.start    = req_valid && stat.idle;
	assign ctl.rsp_free = !rsp_valid_q || rsp_ready;

	srl_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.req    (req),
		.stat   (stat),
		.res    (res),
		.wr     (wr),
		.raddr  (raddr),
		.rdata  (rdata)
	);

	srl_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (CAPACITY)
	) u_store (
		.clk   (clk),
		.we    (wr.we),
		.waddr (wr.addr),
		.wdata (wr.data),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (stat.done) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (stat.done) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
`default_nettype wire
